// ===== rtl/core/pcc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_pkg: types and constants of the packet class counter
// Word formats of both channels, class codes and protocol constants.
// ----------------------------------------------------------------------------
package pcc_pkg;

  typedef enum logic [2:0] {
    CLS_TCP   = 3'd0,
    CLS_UDP   = 3'd1,
    CLS_ARP   = 3'd2,
    CLS_ICMP  = 3'd3,
    CLS_IGMP  = 3'd4,
    CLS_DNS   = 3'd5,
    CLS_HTTP  = 3'd6,
    CLS_OTHER = 3'd7
  } frame_class_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    frame_class_e frame_class;
    logic         was_counted;
    logic [31:0]  class_count;
    logic [31:0]  total_count;
  } out_word_t;

  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_IGMP = 8'd2;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [15:0] PORT_DNS   = 16'd53;
  localparam logic [15:0] PORT_HTTP  = 16'd80;

  localparam logic [6:0] POS_ETYPE_HI = 7'd12;
  localparam logic [6:0] POS_ETYPE_LO = 7'd13;
  localparam logic [6:0] POS_IHL      = 7'd14;
  localparam logic [6:0] POS_PROTO    = 7'd23;
  localparam logic [6:0] POS_MAX      = 7'd127;

  // Register offsets, selected by paddr[2]
  localparam logic REG_CLASS_ENABLE = 1'b0;
  localparam logic REG_SINK_PRESENT = 1'b1;

endpackage
`default_nettype wire

// ===== rtl/core/packet_class_counter_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// packet_class_counter_core: Ethernet/IPv4 frame classifier with counters
// Classifies byte-serial frames and keeps one counter per class and a total.
// ----------------------------------------------------------------------------
// Usage:
//   Feed frame bytes in wire order on the input channel (in_valid_i /
//   in_stall_o), with last_byte set on the final byte of each frame. One
//   byte is taken per cycle while in_stall_o is low. Each byte lands in an
//   input register; from there the header capture, classification and
//   counter update run in one pass and, on a last byte, load the result
//   register, which drives out_valid_o. Frames of any length stream at one
//   byte per cycle unless a last byte waits on a stalled result.
//   The result carries the class code, whether it was counted, and the class
//   and total counters after the update (zero-extended or truncated to 32
//   bits). Bytes that are not last produce no word.
//   While the receiver stalls a pending result, the block keeps taking bytes
//   until a second last byte reaches the input register; it then holds
//   in_stall_o high until the result is taken.
//   Reset clears the frame capture state, all counters, and sets
//   class_enable to all ones and sink_present to one. The APB registers are
//   class_enable at 0x0 and sink_present at 0x4; write them only when idle.
// ----------------------------------------------------------------------------
module packet_class_counter_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // byte input channel
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire pcc_pkg::in_word_t in_data_i,
  // result channel
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output pcc_pkg::out_word_t  out_data_o,
  // configuration port
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [2:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import pcc_pkg::*;

  // configuration registers
  logic [7:0] class_enable_q;
  logic       sink_present_q;

  // input register
  logic       in_valid_q;
  in_word_t   in_q;

  // frame capture state
  logic [6:0]  pos_q, pos_d;
  logic [15:0] etype_q, etype_d;
  logic [3:0]  hdr_words_q, hdr_words_d;
  logic [7:0]  proto_q, proto_d;
  logic [15:0] src_port_q, src_port_d;
  logic [15:0] dst_port_q, dst_port_d;

  // counters
  logic [COUNT_WIDTH-1:0] class_cnt_q [8];
  logic [COUNT_WIDTH-1:0] total_q;

  // result register
  logic      out_valid_q;
  out_word_t out_q;

  logic         advance;
  logic         load_res;
  logic [6:0]   port_pos;
  frame_class_e cls;
  logic         count_en;
  logic [COUNT_WIDTH-1:0] class_next;
  logic [COUNT_WIDTH-1:0] total_next;

  // --------------------------------------------------------------------------
  // Flow control: a non-last byte always drains; a last byte needs the
  // result register free or being taken this cycle.
  // --------------------------------------------------------------------------
  assign advance    = in_valid_q && (!in_q.last_byte || !out_valid_q || !out_stall_i);
  assign load_res   = advance && in_q.last_byte;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Header capture. The port offset uses the header length as updated by
  // this very byte, so a zero length puts the source port at byte 14.
  // --------------------------------------------------------------------------
  always_comb begin
    etype_d     = etype_q;
    hdr_words_d = hdr_words_q;
    proto_d     = proto_q;
    src_port_d  = src_port_q;
    dst_port_d  = dst_port_q;

    if (pos_q == POS_ETYPE_HI) etype_d[15:8] = in_q.frame_byte;
    if (pos_q == POS_ETYPE_LO) etype_d[7:0]  = in_q.frame_byte;
    if (pos_q == POS_IHL)      hdr_words_d   = in_q.frame_byte[3:0];
    if (pos_q == POS_PROTO)    proto_d       = in_q.frame_byte;

    port_pos = POS_IHL + {1'b0, hdr_words_d, 2'b00};
    if (pos_q == port_pos)         src_port_d[15:8] = in_q.frame_byte;
    if (pos_q == port_pos + 7'd1)  src_port_d[7:0]  = in_q.frame_byte;
    if (pos_q == port_pos + 7'd2)  dst_port_d[15:8] = in_q.frame_byte;
    if (pos_q == port_pos + 7'd3)  dst_port_d[7:0]  = in_q.frame_byte;

    // saturate so long frames never wrap back onto header positions
    pos_d = (pos_q < POS_MAX) ? pos_q + 7'd1 : pos_q;
  end

  // --------------------------------------------------------------------------
  // Classification on the updated fields
  // --------------------------------------------------------------------------
  always_comb begin
    if (etype_d == ETYPE_ARP) begin
      cls = CLS_ARP;
    end else if (etype_d != ETYPE_IPV4) begin
      cls = CLS_OTHER;
    end else begin
      case (proto_d)
        PROTO_ICMP: cls = CLS_ICMP;
        PROTO_IGMP: cls = CLS_IGMP;
        PROTO_TCP:  cls = (src_port_d == PORT_HTTP || dst_port_d == PORT_HTTP)
                          ? CLS_HTTP : CLS_TCP;
        PROTO_UDP:  cls = (src_port_d == PORT_DNS || dst_port_d == PORT_DNS)
                          ? CLS_DNS : CLS_UDP;
        default:    cls = CLS_OTHER;
      endcase
    end
  end

  // igmp and other need only their enable bit; the rest need the sink too
  assign count_en = class_enable_q[cls] &&
                    (sink_present_q || cls == CLS_IGMP || cls == CLS_OTHER);

  assign class_next = count_en ? class_cnt_q[cls] + COUNT_WIDTH'(1) : class_cnt_q[cls];
  assign total_next = count_en ? total_q + COUNT_WIDTH'(1) : total_q;

  // --------------------------------------------------------------------------
  // Capture state: advance on every byte, clear after the last one
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      etype_q     <= '0;
      hdr_words_q <= '0;
      proto_q     <= '0;
      src_port_q  <= '0;
      dst_port_q  <= '0;
    end else if (advance) begin
      if (in_q.last_byte) begin
        pos_q       <= '0;
        etype_q     <= '0;
        hdr_words_q <= '0;
        proto_q     <= '0;
        src_port_q  <= '0;
        dst_port_q  <= '0;
      end else begin
        pos_q       <= pos_d;
        etype_q     <= etype_d;
        hdr_words_q <= hdr_words_d;
        proto_q     <= proto_d;
        src_port_q  <= src_port_d;
        dst_port_q  <= dst_port_d;
      end
    end
  end

  // counters wrap at COUNT_WIDTH bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) class_cnt_q[i] <= '0;
      total_q <= '0;
    end else if (load_res) begin
      class_cnt_q[cls] <= class_next;
      total_q          <= total_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register: hold while stalled, drop valid once taken
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_res) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      out_q.frame_class <= cls;
      out_q.was_counted <= count_en;
      out_q.class_count <= 32'(class_next);
      out_q.total_count <= 32'(total_next);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_enable_q <= 8'hFF;
      sink_present_q <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_CLASS_ENABLE: class_enable_q <= pwdata[7:0];
        REG_SINK_PRESENT: sink_present_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CLASS_ENABLE: prdata = {24'd0, class_enable_q};
      REG_SINK_PRESENT: prdata = {31'd0, sink_present_q};
      default:          prdata = '0;
    endcase
  end

  assign pready = 1'b1;

`ifndef NO_ASSERTIONS
  // a stall is only raised with a byte waiting in the input register
  a_stall_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stall without a pending byte");

  // a classified frame shows up as a result word on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_res |=> out_valid_o)
    else $error("result word missing after last byte");

  // the total in a shown word matches the live total counter
  a_total_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.total_count == 32'(total_q))
    else $error("result total out of step with counter");

  // capture state starts over after every frame
  a_frame_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_res |=> (pos_q == '0 && etype_q == '0 && hdr_words_q == '0))
    else $error("frame capture not cleared");
`endif

endmodule
`default_nettype wire
